// ===== src/irc_tok_pkg.sv =====
// ----------------------------------------------------------------------------
// irc_tok_pkg
// Shared types and constants of the IRC message tokenizer.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned CLASS_W          = 4;
   localparam int unsigned INDEX_W          = 6;
   localparam int unsigned COUNT_W          = 7;
   localparam int unsigned SOURCE_W         = 2;
   localparam int unsigned MAX_PARAMS_DEF   = 64;

   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
   localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   localparam logic [CLASS_W-1:0] CLS_PREFIX_COLON = 4'd0;
   localparam logic [CLASS_W-1:0] CLS_NICK         = 4'd1;
   localparam logic [CLASS_W-1:0] CLS_USER         = 4'd2;
   localparam logic [CLASS_W-1:0] CLS_HOST         = 4'd3;
   localparam logic [CLASS_W-1:0] CLS_PREFIX_SEP   = 4'd4;
   localparam logic [CLASS_W-1:0] CLS_SPACE        = 4'd5;
   localparam logic [CLASS_W-1:0] CLS_COMMAND      = 4'd6;
   localparam logic [CLASS_W-1:0] CLS_PARAM        = 4'd7;
   localparam logic [CLASS_W-1:0] CLS_TRAIL_COLON  = 4'd8;
   localparam logic [CLASS_W-1:0] CLS_TRAIL_TEXT   = 4'd9;

   localparam logic [SOURCE_W-1:0] SRC_PEER  = 2'd0;
   localparam logic [SOURCE_W-1:0] SRC_USER  = 2'd1;
   localparam logic [SOURCE_W-1:0] SRC_OTHER = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0]   out_byte;
      logic [CLASS_W-1:0]  field_class;
      logic [INDEX_W-1:0]  param_index;
      logic                field_start;
      logic                message_end;
      logic [SOURCE_W-1:0] source_type;
      logic [COUNT_W-1:0]  param_count;
      logic                no_command;
   } result_type;

endpackage

// ===== src/irc_tok_parser.sv =====
// ----------------------------------------------------------------------------
// irc_tok_parser
// Per-message state machine; tags the presented byte and advances on a step.
// ----------------------------------------------------------------------------
module irc_tok_parser #(
   parameter int unsigned MAX_PARAMS = irc_tok_pkg::MAX_PARAMS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [irc_tok_pkg::BYTE_W-1:0]    data_byte,
   input  logic                              last_byte,
   input  logic                              old_spacing,
   output irc_tok_pkg::result_type           result
);

   typedef enum logic [2:0] {
      PH_START, PH_PREFIX, PH_CMD, PH_PARAM, PH_TRAIL
   } phase_type;

   typedef enum logic [1:0] {
      PART_NICK, PART_USER, PART_HOST
   } part_type;

   localparam logic [irc_tok_pkg::COUNT_W-1:0] COUNT_MAX =
      irc_tok_pkg::COUNT_W'(MAX_PARAMS);
   localparam logic [irc_tok_pkg::COUNT_W-1:0] INDEX_SAT =
      irc_tok_pkg::COUNT_W'((1 << irc_tok_pkg::INDEX_W) - 1);

   phase_type                         phase_ff, phase_in;
   part_type                          part_ff, part_in;
   logic                              prefix_ff, prefix_in;
   logic                              bang_ff, bang_in;
   logic                              at_ff, at_in;
   logic                              begin_ff, begin_in;
   logic [irc_tok_pkg::COUNT_W-1:0]   params_ff, params_in;
   logic                              cmd_ff, cmd_in;

   logic [irc_tok_pkg::CLASS_W-1:0]   cls;
   logic                              fs;
   logic                              sp;
   logic                              count;
   logic [irc_tok_pkg::COUNT_W-1:0]   idx;

   assign sp = (data_byte == irc_tok_pkg::CH_SPACE);

   always_comb begin
      phase_in  = phase_ff;
      part_in   = part_ff;
      prefix_in = prefix_ff;
      bang_in   = bang_ff;
      at_in     = at_ff;
      begin_in  = begin_ff;
      cmd_in    = cmd_ff;
      cls       = irc_tok_pkg::CLS_SPACE;
      fs        = 1'b0;
      count     = 1'b0;
      case (phase_ff)
         PH_START: begin
            if (data_byte == irc_tok_pkg::CH_COLON) begin
               cls       = irc_tok_pkg::CLS_PREFIX_COLON;
               fs        = 1'b1;
               prefix_in = 1'b1;
               phase_in  = PH_PREFIX;
               part_in   = PART_NICK;
               begin_in  = 1'b1;
            end else begin
               cmd_in = 1'b1;
               fs     = 1'b1;
               if (sp) begin
                  phase_in = PH_PARAM;
                  begin_in = 1'b1;
               end else begin
                  cls      = irc_tok_pkg::CLS_COMMAND;
                  phase_in = PH_CMD;
                  begin_in = 1'b0;
               end
            end
         end
         PH_PREFIX: begin
            if (sp) begin
               phase_in = PH_CMD;
               begin_in = 1'b1;
            end else if (part_ff == PART_NICK) begin
               if (data_byte == irc_tok_pkg::CH_BANG && !bang_ff) begin
                  cls      = irc_tok_pkg::CLS_PREFIX_SEP;
                  bang_in  = 1'b1;
                  part_in  = PART_USER;
                  begin_in = 1'b1;
               end else begin
                  cls      = irc_tok_pkg::CLS_NICK;
                  fs       = begin_ff;
                  begin_in = 1'b0;
               end
            end else if (part_ff == PART_USER) begin
               if (data_byte == irc_tok_pkg::CH_AT) begin
                  cls      = irc_tok_pkg::CLS_PREFIX_SEP;
                  at_in    = 1'b1;
                  part_in  = PART_HOST;
                  begin_in = 1'b1;
               end else begin
                  cls      = irc_tok_pkg::CLS_USER;
                  fs       = begin_ff;
                  begin_in = 1'b0;
               end
            end else begin
               cls      = irc_tok_pkg::CLS_HOST;
               fs       = begin_ff;
               begin_in = 1'b0;
            end
         end
         PH_CMD: begin
            if (begin_ff) begin
               if (sp && old_spacing) begin
                  cls = irc_tok_pkg::CLS_SPACE;
               end else if (sp) begin
                  cmd_in   = 1'b1;
                  fs       = 1'b1;
                  phase_in = PH_PARAM;
                  begin_in = 1'b1;
               end else begin
                  cmd_in   = 1'b1;
                  cls      = irc_tok_pkg::CLS_COMMAND;
                  fs       = 1'b1;
                  begin_in = 1'b0;
               end
            end else if (sp) begin
               phase_in = PH_PARAM;
               begin_in = 1'b1;
            end else begin
               cls = irc_tok_pkg::CLS_COMMAND;
            end
         end
         PH_PARAM: begin
            if (begin_ff) begin
               if (sp && old_spacing) begin
                  cls = irc_tok_pkg::CLS_SPACE;
               end else if (sp) begin
                  count = 1'b1;
                  fs    = 1'b1;
               end else if (data_byte == irc_tok_pkg::CH_COLON) begin
                  count    = 1'b1;
                  cls      = irc_tok_pkg::CLS_TRAIL_COLON;
                  fs       = 1'b1;
                  phase_in = PH_TRAIL;
               end else begin
                  count    = 1'b1;
                  cls      = irc_tok_pkg::CLS_PARAM;
                  fs       = 1'b1;
                  begin_in = 1'b0;
               end
            end else if (sp) begin
               begin_in = 1'b1;
            end else begin
               cls = irc_tok_pkg::CLS_PARAM;
            end
         end
         default: begin
            cls      = irc_tok_pkg::CLS_TRAIL_TEXT;
            phase_in = PH_TRAIL;
         end
      endcase
      params_in = (count && params_ff < COUNT_MAX) ? params_ff + 1'b1 : params_ff;
   end

   always_comb begin
      idx = (params_in == '0) ? '0 : params_in - 1'b1;
      if (idx > INDEX_SAT) begin
         idx = INDEX_SAT;
      end
      result.out_byte    = data_byte;
      result.field_class = cls;
      result.field_start = fs;
      result.message_end = last_byte;
      if (cls <= irc_tok_pkg::CLS_PREFIX_SEP || cls == irc_tok_pkg::CLS_COMMAND) begin
         result.param_index = '0;
      end else begin
         result.param_index = idx[irc_tok_pkg::INDEX_W-1:0];
      end
      if (last_byte) begin
         result.source_type = !prefix_in ? irc_tok_pkg::SRC_PEER :
                              (bang_in && at_in) ? irc_tok_pkg::SRC_USER :
                              irc_tok_pkg::SRC_OTHER;
         result.param_count = params_in;
         result.no_command  = !cmd_in;
      end else begin
         result.source_type = irc_tok_pkg::SRC_PEER;
         result.param_count = '0;
         result.no_command  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff  <= PH_START;
         part_ff   <= PART_NICK;
         prefix_ff <= 1'b0;
         bang_ff   <= 1'b0;
         at_ff     <= 1'b0;
         begin_ff  <= 1'b1;
         params_ff <= '0;
         cmd_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         part_ff   <= part_in;
         prefix_ff <= prefix_in;
         bang_ff   <= bang_in;
         at_ff     <= at_in;
         begin_ff  <= begin_in;
         params_ff <= params_in;
         cmd_ff    <= cmd_in;
      end
   end

endmodule

// ===== src/irc_tok_outreg.sv =====
// ----------------------------------------------------------------------------
// irc_tok_outreg
// Result register; loads while empty or while its word is being taken.
// ----------------------------------------------------------------------------
module irc_tok_outreg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  irc_tok_pkg::result_type   in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output irc_tok_pkg::result_type   out_data
);

   logic                     valid_ff;
   irc_tok_pkg::result_type  data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

// ===== src/irc_message_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// irc_message_tokenizer_top
// Streaming tagger for IRC message lines, one result word per input byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one character per word, req_tlast on the final one.
//   rsp_* returns the character with its tag, registered, in the cycle after acceptance;
//   the word with rsp_tlast also carries the message summary.
//   csr_* writes old_spacing (csr_data); csr_ready is always high. Write it
//   only while no message is in flight.
//   Throughput is one byte per cycle while the receiver takes every word,
//   set by the parser state update feeding the result register.
//   When the receiver stalls, the result register holds its word and
//   req_tready drops until it is taken; a word is taken and a new one
//   loaded in the same cycle.
//   Reset clears the parser to start of message, old_spacing to 0 and
//   empties the result register.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_top #(
   parameter int unsigned MAX_PARAMS = irc_tok_pkg::MAX_PARAMS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_byte[7:0], param_index[13:8],
                                    // field_start[14], source_type[16:15],
                                    // param_count[23:17], no_command[24]
   output logic [3:0]  rsp_tuser,   // field_class[3:0]
   output logic        rsp_tlast,   // message_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // old_spacing
);

   logic                     old_spacing_ff;
   logic                     step;
   irc_tok_pkg::result_type  tag;
   irc_tok_pkg::result_type  rsp;

   assign csr_ready = 1'b1;
   assign step      = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         old_spacing_ff <= 1'b0;
      end else if (csr_valid) begin
         old_spacing_ff <= csr_data;
      end
   end

   irc_tok_parser #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .old_spacing (old_spacing_ff),
      .result      (tag)
   );

   irc_tok_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (tag),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = {7'b0, rsp.no_command, rsp.param_count, rsp.source_type,
                       rsp.field_start, rsp.param_index, rsp.out_byte};
   assign rsp_tuser = rsp.field_class;
   assign rsp_tlast = rsp.message_end;

endmodule

// ===== src/irc_tok_checker.sv =====
// ----------------------------------------------------------------------------
// irc_tok_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module irc_tok_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // summary only on the last word
   a_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[24:15] == 10'd0)
      else $error("summary fields set on a non-final word");

   // prefix and command bytes carry index 0
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser <= irc_tok_pkg::CLS_PREFIX_SEP ||
                     rsp_tuser == irc_tok_pkg::CLS_COMMAND) |-> rsp_tdata[13:8] == 6'd0)
      else $error("prefix or command byte with nonzero index");

   // an empty result register always takes a word
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind irc_message_tokenizer_top irc_tok_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
